FILE: hdl/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the metaball pixel shader.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 50;

    // Working word of the datapath, Q8.24 values and wide intermediates
    typedef logic signed [33:0] t_word;
    // Operand of the shared multiplier
    typedef logic signed [24:0] t_mop;

    localparam t_word ONE_Q24       = 34'sd16777216;
    localparam t_word THREE_HALF_PI = 34'sd79060768;
    localparam t_word TWO_PI        = 34'sd105414357;
    localparam t_word HALF_PI       = 34'sd26353589;
    localparam t_word PI_Q24        = 34'sd52707179;
    localparam t_word SIN_BIAS      = 34'sd2785856;
    localparam t_word COS_BIAS      = 34'sd8333243;
    localparam t_word SIN_DIV       = 34'sd131;
    localparam t_word COS_DIV       = 34'sd27;
    localparam t_word SQRT_LIMIT    = 34'sd127;
    localparam t_word DIST_MIN      = 34'sd100;
    localparam t_word DIST_MAX      = 34'sd10000;
    localparam t_word FALL_NUM      = t_word'(16777216 * 6 / 10);
    localparam t_word FIELD_BIAS    = t_word'(16777216 * 22 / 10);
    localparam t_word RED_GAIN      = t_word'(255 * 17);
    localparam t_word GREEN_GAIN    = t_word'(255 * 8);
    localparam t_word CH_DIV        = 34'sd10;
    localparam t_word CH_MAX        = 34'sd255;

    typedef struct packed {
        logic [6:0] pixel_col;
        logic [5:0] pixel_row;
    } t_coord;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Signed divide by 4096, truncating toward zero
    function automatic t_word sdiv4096(input t_word x);
        t_word adj;
        adj = (x < 0) ? (x + t_word'(4095)) : x;
        return adj >>> 12;
    endfunction

    function automatic logic [7:0] clamp8(input t_word x);
        logic [7:0] res;
        if (x > CH_MAX) begin
            res = 8'hFF;
        end else if (x < 0) begin
            res = 8'h00;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/metaball_pixel_shader_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metaball_pixel_shader_top
// Shades one pixel of a three-ball metaball field in Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (t_coord)
// out       output     o_out_valid / i_out_ready  o_out_item (t_pixel)
// cfg       input      i_cfg_we                   i_cfg_data (frame_time)
//
// One pixel is computed step by step. A single shared restoring divider
// serves every division, including each Newton step of the three square
// roots, and the angle reduction loops subtract one turn per cycle.
// A finished pixel sits in the output register; the next item is accepted
// while it waits. Reset is synchronous and clears frame_time to zero.
// ----------------------------------------------------------------------------
module metaball_pixel_shader_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire mbps_pkg::t_coord i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output mbps_pkg::t_pixel    o_out_item,
    input  wire                 i_cfg_we,
    input  wire  [30:0]         i_cfg_data
);
    import mbps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_U, S_V,
        S_TLOAD, S_TRED, S_TFOLD, S_TQ, S_TSQ, S_TT, S_TST, S_TSIN, S_TEND,
        S_FLOAD, S_FSQ1, S_FSQ2, S_FSCALE, S_FNEWT, S_FNEWT2, S_FDIST, S_FACC,
        S_SHADE, S_SR, S_SR2, S_SG, S_SG2, S_FIN
    } t_state;

    t_state      r_state, n_state, r_ret, n_ret;
    logic [30:0] r_time, n_time;
    logic [5:0]  r_row, n_row;
    t_word       r_u, n_u, r_v, n_v;
    t_word       r_x, n_x, r_q, n_q, r_sq, n_sq, r_n, n_n, r_sum, n_sum;
    t_word       r_trig [4];
    t_word       n_trig [4];
    logic [1:0]  r_tidx, n_tidx, r_fidx, n_fidx;
    logic        r_cos, n_cos, r_neg, n_neg, r_bneg, n_bneg;
    logic [3:0]  r_sc, n_sc;
    t_mop        r_ma, n_ma, r_mb, n_mb;
    logic [31:0] r_dq, n_dq, r_drem, n_drem, r_dvs, n_dvs;
    logic [4:0]  r_dcnt, n_dcnt;
    logic        r_dneg, n_dneg;
    logic [7:0]  r_red, n_red, r_green, n_green;
    logic        r_out_valid, n_out_valid;
    t_pixel      r_out, n_out;

    logic signed [49:0] w_prod;
    t_word              w_mul;
    t_word              w_quot;

    assign w_prod = r_ma * r_mb;
    assign w_mul  = t_word'(w_prod);
    assign w_quot = r_dneg ? -t_word'(r_dq) : t_word'(r_dq);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        logic        d_start;
        t_word       d_dvd;
        logic [31:0] d_dvs;
        t_state      d_ret;
        logic [32:0] rem_sh;
        t_word       tmp_a;
        t_word       tmp_b;
        t_word       diff;

        n_state = r_state;  n_ret = r_ret;  n_time = r_time;
        n_row = r_row;  n_u = r_u;  n_v = r_v;
        n_x = r_x;  n_q = r_q;  n_sq = r_sq;  n_n = r_n;  n_sum = r_sum;
        n_trig = r_trig;  n_tidx = r_tidx;  n_fidx = r_fidx;
        n_cos = r_cos;  n_neg = r_neg;  n_bneg = r_bneg;  n_sc = r_sc;
        n_ma = r_ma;  n_mb = r_mb;
        n_dq = r_dq;  n_drem = r_drem;  n_dvs = r_dvs;
        n_dcnt = r_dcnt;  n_dneg = r_dneg;
        n_red = r_red;  n_green = r_green;
        n_out_valid = r_out_valid;  n_out = r_out;
        d_start = 1'b0;  d_dvd = '0;  d_dvs = '0;  d_ret = S_IDLE;
        rem_sh = '0;  tmp_a = '0;  tmp_b = '0;  diff = '0;

        if (i_cfg_we) begin
            n_time = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_row   = i_in_item.pixel_row;
                    d_start = 1'b1;
                    d_dvd   = (t_word'({i_in_item.pixel_col, 1'b0})
                               - t_word'(SCREEN_WIDTH)) <<< 24;
                    d_dvs   = 32'(SCREEN_HEIGHT);
                    d_ret   = S_U;
                end
            end
            S_DIV: begin
                // one restoring step per cycle
                rem_sh = {r_drem, r_dq[31]};
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_drem = 32'(rem_sh - {1'b0, r_dvs});
                    n_dq   = {r_dq[30:0], 1'b1};
                end else begin
                    n_drem = rem_sh[31:0];
                    n_dq   = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = r_ret;
                end
            end
            S_U: begin
                n_u     = w_quot;
                d_start = 1'b1;
                d_dvd   = (t_word'({r_row, 1'b0}) - t_word'(SCREEN_HEIGHT)) <<< 24;
                d_dvs   = 32'(SCREEN_HEIGHT);
                d_ret   = S_V;
            end
            S_V: begin
                n_v     = w_quot;
                n_tidx  = 2'd0;
                n_state = S_TLOAD;
            end
            S_TLOAD: begin
                case (r_tidx)
                    2'd0, 2'd1: n_x = t_word'(r_time >> 1);
                    2'd2:       n_x = t_word'(r_time >> 2);
                    default:    n_x = t_word'(r_time);
                endcase
                n_cos   = (r_tidx == 2'd1);
                n_neg   = 1'b0;
                n_state = S_TRED;
            end
            S_TRED: begin
                if (r_x > THREE_HALF_PI) begin
                    n_x = r_x - TWO_PI;
                end else begin
                    n_state = S_TFOLD;
                end
            end
            S_TFOLD: begin
                if (r_cos) begin
                    // cosine past the quarter turn: negated sine of x - pi/2
                    if (r_x > HALF_PI) begin
                        n_x   = r_x - HALF_PI;
                        n_cos = 1'b0;
                        n_neg = 1'b1;
                    end else begin
                        n_state = S_TQ;
                    end
                end else begin
                    if (r_x > HALF_PI) begin
                        n_x = PI_Q24 - r_x;
                    end
                    n_state = S_TQ;
                end
            end
            S_TQ: begin
                tmp_a   = sdiv4096(r_x);
                n_q     = tmp_a;
                n_ma    = t_mop'(tmp_a);
                n_mb    = t_mop'(tmp_a);
                n_state = S_TSQ;
            end
            S_TSQ: begin
                n_sq    = w_mul;
                d_start = 1'b1;
                d_dvd   = w_mul;
                d_dvs   = r_cos ? COS_DIV[31:0] : SIN_DIV[31:0];
                d_ret   = S_TT;
            end
            S_TT: begin
                tmp_a   = sdiv4096(w_quot - (r_cos ? COS_BIAS : SIN_BIAS));
                n_ma    = t_mop'(r_sq >>> 12);
                n_mb    = t_mop'(tmp_a);
                n_state = S_TST;
            end
            S_TST: begin
                if (r_cos) begin
                    n_x     = ONE_Q24 + w_mul;
                    n_state = S_TEND;
                end else begin
                    n_ma    = t_mop'(r_q);
                    n_mb    = t_mop'(sdiv4096(ONE_Q24 + w_mul));
                    n_state = S_TSIN;
                end
            end
            S_TSIN: begin
                n_x     = w_mul;
                n_state = S_TEND;
            end
            S_TEND: begin
                n_trig[r_tidx] = r_neg ? -r_x : r_x;
                n_tidx         = r_tidx + 2'd1;
                if (r_tidx == 2'd3) begin
                    n_fidx  = 2'd0;
                    n_sum   = '0;
                    n_state = S_FLOAD;
                end else begin
                    n_state = S_TLOAD;
                end
            end
            S_FLOAD: begin
                tmp_a = ((r_fidx == 2'd2) ? r_trig[2] : r_trig[0]) - r_u;
                case (r_fidx)
                    2'd0:    tmp_b = r_trig[0] - r_v;
                    2'd1:    tmp_b = r_trig[1] - r_v;
                    default: tmp_b = r_trig[3] - r_v;
                endcase
                n_ma    = t_mop'(sdiv4096(tmp_a));
                n_mb    = t_mop'(sdiv4096(tmp_a));
                n_q     = sdiv4096(tmp_b);
                n_state = S_FSQ1;
            end
            S_FSQ1: begin
                n_n     = w_mul;
                n_ma    = t_mop'(r_q);
                n_mb    = t_mop'(r_q);
                n_state = S_FSQ2;
            end
            S_FSQ2: begin
                n_n     = r_n + w_mul;
                n_sc    = '0;
                n_state = S_FSCALE;
            end
            S_FSCALE: begin
                // quarter the radicand, double the root later
                if (r_n > SQRT_LIMIT) begin
                    n_n  = r_n >>> 2;
                    n_sc = r_sc + 4'd1;
                end else begin
                    n_n     = r_n <<< 24;
                    n_x     = ONE_Q24;
                    n_state = S_FNEWT;
                end
            end
            S_FNEWT: begin
                if (r_x == 0) begin
                    n_state = S_FDIST;
                end else begin
                    d_start = 1'b1;
                    d_dvd   = r_n;
                    d_dvs   = r_x[31:0];
                    d_ret   = S_FNEWT2;
                end
            end
            S_FNEWT2: begin
                tmp_a = (r_x + w_quot) >>> 1;
                diff  = tmp_a - r_x;
                n_x   = tmp_a;
                if (diff >= -t_word'(1) && diff <= t_word'(1)) begin
                    n_state = S_FDIST;
                end else begin
                    n_state = S_FNEWT;
                end
            end
            S_FDIST: begin
                tmp_a = (r_x <<< r_sc) >>> 12;
                if (tmp_a > DIST_MAX) begin
                    tmp_a = DIST_MAX;
                end else if (tmp_a < DIST_MIN) begin
                    tmp_a = DIST_MIN;
                end
                d_start = 1'b1;
                d_dvd   = FALL_NUM;
                d_dvs   = tmp_a[31:0];
                d_ret   = S_FACC;
            end
            S_FACC: begin
                n_sum  = r_sum + (w_quot <<< 12);
                n_fidx = r_fidx + 2'd1;
                if (r_fidx == 2'd2) begin
                    n_state = S_SHADE;
                end else begin
                    n_state = S_FLOAD;
                end
            end
            S_SHADE: begin
                tmp_a   = r_sum - FIELD_BIAS;
                n_bneg  = (tmp_a < 0);
                tmp_b   = sdiv4096(tmp_a + ONE_Q24);
                n_q     = tmp_b;
                n_ma    = t_mop'(tmp_b);
                n_mb    = t_mop'(RED_GAIN);
                n_state = S_SR;
            end
            S_SR: begin
                d_start = 1'b1;
                d_dvd   = w_mul;
                d_dvs   = CH_DIV[31:0];
                d_ret   = S_SR2;
            end
            S_SR2: begin
                n_red   = clamp8(sdiv4096(w_quot));
                n_ma    = t_mop'(r_q);
                n_mb    = t_mop'(GREEN_GAIN);
                n_state = S_SG;
            end
            S_SG: begin
                d_start = 1'b1;
                d_dvd   = w_mul;
                d_dvs   = CH_DIV[31:0];
                d_ret   = S_SG2;
            end
            S_SG2: begin
                n_green = clamp8(sdiv4096(w_quot));
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.red   = r_red;
                    n_out.green = r_green;
                    n_out.blue  = r_bneg ? 8'h00 : 8'hFF;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (d_start) begin
            n_dq    = (d_dvd < 0) ? 32'(-d_dvd) : 32'(d_dvd);
            n_dneg  = (d_dvd < 0);
            n_drem  = '0;
            n_dcnt  = '0;
            n_dvs   = d_dvs;
            n_ret   = d_ret;
            n_state = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
        r_row   <= n_row;
        r_u     <= n_u;     r_v     <= n_v;
        r_x     <= n_x;     r_q     <= n_q;
        r_sq    <= n_sq;    r_n     <= n_n;    r_sum <= n_sum;
        r_trig  <= n_trig;
        r_tidx  <= n_tidx;  r_fidx  <= n_fidx;
        r_cos   <= n_cos;   r_neg   <= n_neg;  r_bneg <= n_bneg;
        r_sc    <= n_sc;
        r_ma    <= n_ma;    r_mb    <= n_mb;
        r_dq    <= n_dq;    r_drem  <= n_drem; r_dvs <= n_dvs;
        r_dcnt  <= n_dcnt;  r_dneg  <= n_dneg;
        r_red   <= n_red;   r_green <= n_green;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire
